### sv/sqb_pkg.sv
// ----------------------------------------------------------------------------
// sqb_pkg
// Types and constants shared by the sprite quad batcher modules.
// ----------------------------------------------------------------------------
package sqb_pkg;

  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_BEGIN = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam int QUAD_CNT_W = 15;
  localparam int SLOT_CNT_W = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [16:0] SIN_A = 17'd102943;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] quad_width;
    logic signed [31:0] quad_height;
    logic signed [31:0] depth;
    logic [15:0]        angle;
    logic [15:0]        texture_handle;
    logic [15:0]        shader_handle;
  } item_t;

  typedef struct packed {
    logic                  is_flush;
    logic                  last;
    logic [QUAD_CNT_W-1:0] count;
    logic [15:0]           base_index;
    logic [4:0]            slot;
    logic signed [31:0]    centre_x;
    logic signed [31:0]    centre_y;
    logic signed [31:0]    quad_width;
    logic signed [31:0]    quad_height;
    logic signed [31:0]    depth;
    logic [15:0]           angle;
  } cmd_t;

  typedef struct packed {
    logic                  is_flush;
    logic                  last;
    logic [QUAD_CNT_W-1:0] batch_quads;
    logic [15:0]           vertex_index;
    logic [1:0]            corner;
    logic signed [31:0]    vertex_x;
    logic signed [31:0]    vertex_y;
    logic signed [31:0]    vertex_z;
    logic [4:0]            texture_slot;
  } result_t;

endpackage

### sv/sqb_front.sv
// ----------------------------------------------------------------------------
// sqb_front
// Accepts items, resolves shader and batch flushes, assigns texture slots
// and queues flush markers and quad commands for the back end.
// ----------------------------------------------------------------------------
module sqb_front #(
  parameter int MAX_BATCH_QUADS = 16384,
  parameter int SLOT_TABLE_SIZE = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sqb_pkg::item_t  in_item,
  input  logic [15:0]     dflt_shader,
  input  logic [15:0]     white_tex,
  output logic            q_push,
  output sqb_pkg::cmd_t   q_cmd,
  input  logic            q_full
);
  import sqb_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_TABLE_SIZE);

  typedef enum logic [1:0] {F_IDLE, F_DECIDE, F_FLUSH, F_QUAD} fstate_t;

  fstate_t               state_r;
  item_t                 item_r;
  logic [15:0]           active_r;
  logic [QUAD_CNT_W-1:0] quads_r;
  logic [SLOT_CNT_W-1:0] slots_r;
  logic                  flush_last_r;
  logic [15:0]           handles_r [SLOT_TABLE_SIZE];

  logic [15:0]     shader_eff;
  logic            need_flush;
  logic            hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] new_slot;

  assign shader_eff = (item_r.shader_handle == 16'd0) ? dflt_shader : item_r.shader_handle;
  assign need_flush = (shader_eff != active_r) ||
                      (quads_r >= QUAD_CNT_W'(MAX_BATCH_QUADS)) ||
                      (slots_r >= SLOT_CNT_W'(SLOT_TABLE_SIZE));
  assign new_slot = slots_r[SLOT_W-1:0];

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = SLOT_TABLE_SIZE - 1; i >= 1; i--) begin
      if ((SLOT_CNT_W'(i) < slots_r) && (handles_r[i] == item_r.texture_handle)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
    if ((item_r.texture_handle == 16'd0) || (item_r.texture_handle == white_tex)) begin
      hit      = 1'b1;
      hit_slot = '0;
    end
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = !q_full && ((state_r == F_FLUSH) || (state_r == F_QUAD));

  always_comb begin
    q_cmd             = '0;
    q_cmd.centre_x    = item_r.centre_x;
    q_cmd.centre_y    = item_r.centre_y;
    q_cmd.quad_width  = item_r.quad_width;
    q_cmd.quad_height = item_r.quad_height;
    q_cmd.depth       = item_r.depth;
    q_cmd.angle       = item_r.angle;
    q_cmd.base_index  = {quads_r[13:0], 2'b00};
    q_cmd.slot        = 5'(hit ? hit_slot : new_slot);
    if (state_r == F_FLUSH) begin
      q_cmd.is_flush = 1'b1;
      q_cmd.last     = flush_last_r;
      q_cmd.count    = quads_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      active_r     <= 16'd1;
      quads_r      <= '0;
      slots_r      <= SLOT_CNT_W'(1);
      flush_last_r <= 1'b0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            state_r <= F_DECIDE;
          end
        end
        F_DECIDE: begin
          unique case (item_r.func)
            FUNC_BEGIN: begin
              quads_r <= '0;
              slots_r <= SLOT_CNT_W'(1);
              state_r <= F_IDLE;
            end
            FUNC_FLUSH: begin
              flush_last_r <= 1'b1;
              state_r      <= F_FLUSH;
            end
            FUNC_DRAW: begin
              flush_last_r <= 1'b0;
              active_r     <= shader_eff;
              state_r      <= need_flush ? F_FLUSH : F_QUAD;
            end
            default: state_r <= F_IDLE;
          endcase
        end
        F_FLUSH: begin
          if (!q_full) begin
            quads_r <= '0;
            slots_r <= SLOT_CNT_W'(1);
            state_r <= flush_last_r ? F_IDLE : F_QUAD;
          end
        end
        F_QUAD: begin
          if (!q_full) begin
            if (!hit) begin
              handles_r[new_slot] <= item_r.texture_handle;
              slots_r             <= slots_r + SLOT_CNT_W'(1);
            end
            quads_r <= quads_r + QUAD_CNT_W'(1);
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/sqb_queue.sv
// ----------------------------------------------------------------------------
// sqb_queue
// Short command queue between the front end and the vertex back end.
// ----------------------------------------------------------------------------
module sqb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sqb_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output sqb_pkg::cmd_t cmd_out,
  output logic          empty
);
  import sqb_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign cmd_out = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

### sv/sqb_back.sv
// ----------------------------------------------------------------------------
// sqb_back
// Evaluates sine and cosine of the quad angle step by step, forms the
// rotated corner offsets and emits flush markers and vertices.
// ----------------------------------------------------------------------------
module sqb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  sqb_pkg::cmd_t    q_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output sqb_pkg::result_t out_res
);
  import sqb_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_Z2, B_I1, B_I2, B_Q, B_PROD, B_EMIT, B_FLUSH} bstate_t;

  bstate_t            state_r;
  cmd_t               cmd_r;
  logic [14:0]        xs_r, xc_r;
  logic               negs_r, negc_r;
  logic [14:0]        z2s_r, z2c_r;
  logic [15:0]        i1s_r, i1c_r;
  logic [16:0]        i2s_r, i2c_r;
  logic signed [17:0] s_r, c_r;
  logic signed [49:0] wc_r, hs_r, hc_r, ws_r;
  logic [1:0]         corner_r;
  logic               valid_r;
  result_t            res_r;

  logic [15:0]        ang_c;
  logic [29:0]        sq_s, sq_c;
  logic [27:0]        t1_s, t1_c;
  logic [30:0]        t2_s, t2_c;
  logic [31:0]        t3_s, t3_c;
  logic [17:0]        q_s, q_c;
  logic signed [49:0] w_e, h_e, s_e, c_e;
  logic               sx, sy;
  logic signed [50:0] sum_x, sum_y;
  logic               load;
  logic               emit;

  assign ang_c = q_cmd.angle + QUARTER_TURN;
  assign sq_s  = 30'(xs_r) * 30'(xs_r);
  assign sq_c  = 30'(xc_r) * 30'(xc_r);
  assign t1_s  = 28'(z2s_r) * 28'(SIN_C);
  assign t1_c  = 28'(z2c_r) * 28'(SIN_C);
  assign t2_s  = 31'(z2s_r) * 31'(i1s_r);
  assign t2_c  = 31'(z2c_r) * 31'(i1c_r);
  assign t3_s  = 32'(xs_r) * 32'(i2s_r);
  assign t3_c  = 32'(xc_r) * 32'(i2c_r);
  assign q_s   = t3_s[31:14];
  assign q_c   = t3_c[31:14];

  assign w_e = {{18{cmd_r.quad_width[31]}}, cmd_r.quad_width};
  assign h_e = {{18{cmd_r.quad_height[31]}}, cmd_r.quad_height};
  assign s_e = {{32{s_r[17]}}, s_r};
  assign c_e = {{32{c_r[17]}}, c_r};

  assign sx    = (corner_r == 2'd1) || (corner_r == 2'd2);
  assign sy    = corner_r[1];
  assign sum_x = (sx ? 51'(wc_r) : -51'(wc_r)) + (sy ? 51'(hs_r) : -51'(hs_r));
  assign sum_y = (sy ? 51'(hc_r) : -51'(hc_r)) - (sx ? 51'(ws_r) : -51'(ws_r));

  assign load      = !valid_r || out_ready;
  assign emit      = load && ((state_r == B_EMIT) || (state_r == B_FLUSH));
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      valid_r  <= 1'b0;
      corner_r <= '0;
    end else begin
      if (emit) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cmd_r    <= q_cmd;
            corner_r <= '0;
            xs_r     <= q_cmd.angle[14] ? 15'(15'd16384 - 15'(q_cmd.angle[13:0]))
                                        : {1'b0, q_cmd.angle[13:0]};
            xc_r     <= ang_c[14] ? 15'(15'd16384 - 15'(ang_c[13:0])) : {1'b0, ang_c[13:0]};
            negs_r   <= q_cmd.angle[15];
            negc_r   <= ang_c[15];
            state_r  <= q_cmd.is_flush ? B_FLUSH : B_Z2;
          end
        end
        B_Z2: begin
          z2s_r   <= sq_s[28:14];
          z2c_r   <= sq_c[28:14];
          state_r <= B_I1;
        end
        B_I1: begin
          i1s_r   <= 16'(SIN_B - 17'(t1_s[27:14]));
          i1c_r   <= 16'(SIN_B - 17'(t1_c[27:14]));
          state_r <= B_I2;
        end
        B_I2: begin
          i2s_r   <= SIN_A - 17'(t2_s[30:14]);
          i2c_r   <= SIN_A - 17'(t2_c[30:14]);
          state_r <= B_Q;
        end
        B_Q: begin
          s_r     <= negs_r ? -$signed(q_s) : $signed(q_s);
          c_r     <= negc_r ? -$signed(q_c) : $signed(q_c);
          state_r <= B_PROD;
        end
        B_PROD: begin
          wc_r    <= w_e * c_e;
          hs_r    <= h_e * s_e;
          hc_r    <= h_e * c_e;
          ws_r    <= w_e * s_e;
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (load) begin
            res_r.is_flush     <= 1'b0;
            res_r.last         <= (corner_r == 2'd3);
            res_r.batch_quads  <= '0;
            res_r.vertex_index <= cmd_r.base_index | 16'(corner_r);
            res_r.corner       <= corner_r;
            res_r.vertex_x     <= cmd_r.centre_x + sum_x[48:17];
            res_r.vertex_y     <= cmd_r.centre_y + sum_y[48:17];
            res_r.vertex_z     <= cmd_r.depth;
            res_r.texture_slot <= cmd_r.slot;
            corner_r           <= corner_r + 2'd1;
            if (corner_r == 2'd3) begin
              state_r <= B_IDLE;
            end
          end
        end
        B_FLUSH: begin
          if (load) begin
            res_r.is_flush     <= 1'b1;
            res_r.last         <= cmd_r.last;
            res_r.batch_quads  <= cmd_r.count;
            res_r.vertex_index <= '0;
            res_r.corner       <= '0;
            res_r.vertex_x     <= '0;
            res_r.vertex_y     <= '0;
            res_r.vertex_z     <= '0;
            res_r.texture_slot <= '0;
            state_r            <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### sv/sprite_quad_batcher.sv
// ----------------------------------------------------------------------------
// sprite_quad_batcher
// Turns draw items into the four rotated corner vertices of a quad and keeps
// a batch with a shader and a texture slot table, emitting flush markers.
//
// Items arrive on the in_ stream; in_tuser carries the function code. A draw
// gives four vertex transfers on the out_ stream, preceded by one flush marker
// when the shader changes or the batch is full; a flush item gives one marker;
// a begin item only clears the batch. out_tlast marks the final transfer of
// an item. The front end registers an item and decides on it; a flush item or
// a draw is then pushed to the queue, a draw that needs a flush marker pushing
// the marker first, and the queue holds up to four commands. The back end
// evaluates sine and cosine over four steps, forms the products in one more and
// then emits one vertex a cycle while out_tready does not hold the output. The
// output register holds a result while out_tready is low; the queue then fills
// and in_tready falls.
// Reset clears the batch, sets the active shader and both configuration
// registers to one and needs no clearing pass.
// ----------------------------------------------------------------------------
module sprite_quad_batcher #(
  parameter int MAX_BATCH_QUADS = 16384,
  parameter int SLOT_TABLE_SIZE = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // centre_x, centre_y, quad_width, quad_height, depth, angle, texture_handle,
  // shader_handle
  input  logic [207:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // batch_quads, vertex_index, corner, vertex_x, vertex_y, vertex_z,
  // texture_slot, zero padding
  output logic [135:0] out_tdata,
  // is_flush
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);
  import sqb_pkg::*;

  localparam logic CFG_DFLT_SHADER = 1'b0;
  localparam logic CFG_WHITE_TEX   = 1'b1;

  logic [15:0] dflt_shader_r;
  logic [15:0] white_tex_r;
  item_t       item;
  cmd_t        push_cmd, head_cmd;
  logic        push, full, pop, empty;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_shader_r <= 16'd1;
      white_tex_r   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DFLT_SHADER: dflt_shader_r <= cfg_wdata;
        CFG_WHITE_TEX:   white_tex_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign item.func           = in_tuser;
  assign item.centre_x       = in_tdata[31:0];
  assign item.centre_y       = in_tdata[63:32];
  assign item.quad_width     = in_tdata[95:64];
  assign item.quad_height    = in_tdata[127:96];
  assign item.depth          = in_tdata[159:128];
  assign item.angle          = in_tdata[175:160];
  assign item.texture_handle = in_tdata[191:176];
  assign item.shader_handle  = in_tdata[207:192];

  sqb_front #(
    .MAX_BATCH_QUADS (MAX_BATCH_QUADS),
    .SLOT_TABLE_SIZE (SLOT_TABLE_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (item),
    .dflt_shader (dflt_shader_r),
    .white_tex   (white_tex_r),
    .q_push      (push),
    .q_cmd       (push_cmd),
    .q_full      (full)
  );

  sqb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (push_cmd),
    .full    (full),
    .pop     (pop),
    .cmd_out (head_cmd),
    .empty   (empty)
  );

  sqb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_pop     (pop),
    .q_cmd     (head_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.texture_slot, res.vertex_z, res.vertex_y, res.vertex_x,
                      res.corner, res.vertex_index, res.batch_quads};
  assign out_tuser = res.is_flush;
  assign out_tlast = res.last;

endmodule

### dv/sprite_quad_batcher_test.sv
// ----------------------------------------------------------------------------
// sprite_quad_batcher_test
// Self-checking testbench for the sprite quad batcher. Draw, begin and flush
// items are sent on the input stream with random idling on both sides, and
// every vertex and flush-marker transfer is compared against a cycle-free
// prediction of the batch, shader and texture slot state.
// ----------------------------------------------------------------------------
module sprite_quad_batcher_test;
  import sqb_pkg::*;

  localparam int CFG_DFLT_SHADER = 0;
  localparam int CFG_WHITE_TEX   = 1;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [207:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_we;
  logic         cfg_addr;
  logic [15:0]  cfg_wdata;

  sprite_quad_batcher dut (.*);

  typedef struct packed {
    logic        is_flush;
    logic        last;
    logic [14:0] batch_quads;
    logic [15:0] vertex_index;
    logic [1:0]  corner;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_z;
    logic [4:0]  texture_slot;
  } vertex_t;

  vertex_t     pending_vertices[$];
  int          error_count;
  int          result_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;
  int          quiet_cycles;

  logic [15:0] dflt_shader_h;
  logic [15:0] white_tex_h;
  logic [15:0] active_shader;
  logic [14:0] quads_in_batch;
  logic [5:0]  slots_in_use;
  logic [15:0] slot_handles[32];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sine_q16(logic [15:0] a);
    longint x, z2, i1, i2, mag;
    x = a[14] ? 16384 - a[13:0] : a[13:0];
    z2 = (x * x) >>> 14;
    i1 = 42047 - ((z2 * 4640) >>> 14);
    i2 = 102943 - ((z2 * i1) >>> 14);
    mag = (x * i2) >>> 14;
    return a[15] ? -mag : mag;
  endfunction

  function automatic vertex_t flush_marker();
    vertex_t v;
    v = '0;
    v.is_flush = 1'b1;
    v.batch_quads = quads_in_batch;
    quads_in_batch = '0;
    slots_in_use = 6'd1;
    return v;
  endfunction

  task automatic predict_quad(item_t it);
    logic [15:0] shader;
    logic [4:0]  slot;
    bit          found;
    longint      s, c, lx, ly, ox, oy;
    vertex_t     v;
    if (it.func == FUNC_BEGIN) begin
      quads_in_batch = '0;
      slots_in_use = 6'd1;
    end else if (it.func == FUNC_FLUSH) begin
      v = flush_marker();
      v.last = 1'b1;
      pending_vertices.push_back(v);
    end else if (it.func == FUNC_DRAW) begin
      shader = it.shader_handle == 0 ? dflt_shader_h : it.shader_handle;
      if (shader != active_shader) begin
        pending_vertices.push_back(flush_marker());
        active_shader = shader;
      end
      if (quads_in_batch >= 16384 || slots_in_use >= 32)
        pending_vertices.push_back(flush_marker());
      slot = '0;
      if (it.texture_handle != 0) begin
        found = it.texture_handle == white_tex_h;
        for (int i = 1; !found && i < slots_in_use; i++) begin
          if (slot_handles[i] == it.texture_handle) begin
            found = 1;
            slot = 5'(i);
          end
        end
        if (!found) begin
          slot = slots_in_use[4:0];
          slot_handles[slot] = it.texture_handle;
          slots_in_use++;
        end
      end
      s = sine_q16(it.angle);
      c = sine_q16(it.angle + 16'd16384);
      for (int i = 0; i < 4; i++) begin
        lx = (i == 1 || i == 2) ? longint'(it.quad_width) : -longint'(it.quad_width);
        ly = (i >= 2) ? longint'(it.quad_height) : -longint'(it.quad_height);
        ox = (lx * c + ly * s) >>> 17;
        oy = (ly * c - lx * s) >>> 17;
        v = '0;
        v.vertex_index = {quads_in_batch[13:0], 2'(i)};
        v.corner = 2'(i);
        v.vertex_x = 32'(longint'(it.centre_x) + ox);
        v.vertex_y = 32'(longint'(it.centre_y) + oy);
        v.vertex_z = it.depth;
        v.texture_slot = slot;
        v.last = (i == 3);
        pending_vertices.push_back(v);
      end
      quads_in_batch++;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h (transfer %0d)", what, got, want,
             result_count);
    error_count++;
  endtask

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {it.shader_handle, it.texture_handle, it.angle, it.depth,
                  it.quad_height, it.quad_width, it.centre_y, it.centre_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_quad(it);
  endtask

  task automatic write_register(int idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx[0];
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_DFLT_SHADER) dflt_shader_h = value;
    else white_tex_h = value;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.is_flush = out_tuser;
      got.last = out_tlast;
      {got.texture_slot, got.vertex_z, got.vertex_y, got.vertex_x, got.corner,
       got.vertex_index, got.batch_quads} = out_tdata[133:0];
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected transfer", got.vertex_x, 32'd0);
      end else begin
        want = pending_vertices.pop_front();
        if (got.is_flush !== want.is_flush)
          report_mismatch("is_flush", 32'(got.is_flush), 32'(want.is_flush));
        if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.batch_quads !== want.batch_quads)
          report_mismatch("batch_quads", 32'(got.batch_quads), 32'(want.batch_quads));
        if (got.vertex_index !== want.vertex_index)
          report_mismatch("vertex_index", 32'(got.vertex_index), 32'(want.vertex_index));
        if (got.corner !== want.corner)
          report_mismatch("corner", 32'(got.corner), 32'(want.corner));
        if (got.vertex_x !== want.vertex_x) report_mismatch("vertex_x", got.vertex_x, want.vertex_x);
        if (got.vertex_y !== want.vertex_y) report_mismatch("vertex_y", got.vertex_y, want.vertex_y);
        if (got.vertex_z !== want.vertex_z) report_mismatch("vertex_z", got.vertex_z, want.vertex_z);
        if (got.texture_slot !== want.texture_slot)
          report_mismatch("texture_slot", 32'(got.texture_slot), 32'(want.texture_slot));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_vertices.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic item_t random_quad();
    item_t it;
    it.func = FUNC_DRAW;
    it.centre_x = $urandom;
    it.centre_y = $urandom;
    it.quad_width = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22);
    it.quad_height = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22);
    it.depth = $urandom;
    it.angle = 16'($urandom);
    it.texture_handle = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(12));
    it.shader_handle = $urandom_range(7) == 0 ? 16'($urandom_range(3)) : 16'd0;
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    logic [31:0] extremes[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    logic [15:0] angles[6] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hffff, 16'd8192};
    for (int i = 0; i < 6; i++) begin
      it = random_quad();
      it.angle = angles[i];
      it.centre_x = extremes[i % 4];
      it.centre_y = extremes[(i + 1) % 4];
      it.quad_width = extremes[(i + 2) % 4];
      it.quad_height = extremes[(i + 3) % 4];
      it.depth = extremes[i % 4];
      it.texture_handle = i == 0 ? 16'd0 : i == 1 ? 16'hffff : i == 2 ? 16'd1 : 16'd5;
      it.shader_handle = i == 4 ? 16'hffff : 16'd0;
      send_item(it);
    end
    it.func = FUNC_FLUSH;
    send_item(it);
    it.func = FUNC_FLUSH;
    send_item(it);
    it.func = FUNC_UNUSED;
    send_item(it);
    it = random_quad();
    it.shader_handle = 16'd0;
    send_item(it);
    it.func = FUNC_BEGIN;
    send_item(it);
    wait_drained();
  endtask

  // Enough distinct textures to fill the slot table and force a flush.
  task automatic test_slot_overflow();
    item_t it;
    for (int i = 0; i < 36; i++) begin
      it = random_quad();
      it.shader_handle = 16'd0;
      it.texture_handle = 16'(100 + i);
      send_item(it);
    end
    it.texture_handle = 16'd100;
    send_item(it);
    wait_drained();
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      repeat (10) send_item(random_quad());
    join
    wait_drained();
  endtask

  task automatic test_random(int count);
    item_t it;
    for (int i = 0; i < count; i++) begin
      it = random_quad();
      case ($urandom_range(19))
        0: it.func = FUNC_BEGIN;
        1: it.func = FUNC_FLUSH;
        2: it.func = FUNC_UNUSED;
        default: it.func = FUNC_DRAW;
      endcase
      send_item(it);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_wdata = '0;
    recv_hold = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 56;
    dflt_shader_h = 16'd1;
    white_tex_h = 16'd1;
    active_shader = 16'd1;
    quads_in_batch = '0;
    slots_in_use = 6'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_register(CFG_DFLT_SHADER, 16'hffff);
    write_register(CFG_WHITE_TEX, 16'd5);
    test_slot_overflow();
    test_random(30);
    send_idle_pct = 56;
    recv_idle_pct = 8;
    write_register(CFG_DFLT_SHADER, 16'd1);
    write_register(CFG_WHITE_TEX, 16'hffff);
    test_backpressure();
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(CFG_DFLT_SHADER, 16'd2);
    write_register(CFG_WHITE_TEX, 16'd1);
    test_random(30);

    $display("Covered draws at extreme sizes and angles, begins, flushes, shader and");
    $display("slot-table flushes, back-pressure and %0d result transfers.", result_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
